// File: sv/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants for the chained hash map with dense storage.
// ----------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

   localparam int CAPACITY_DEF    = 32;
   localparam int KEY_WIDTH_DEF   = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_ERASE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] result_value;
      logic        status;
      logic [5:0]  entry_count;
   } rsp_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic scan_start;
      logic wr_value;
      logic wr_new;
      logic wr_move;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: sv/chm_cell.sv
// ----------------------------------------------------------------------------
// chm_cell
// One table slot: holds a key and a value, matches the broadcast key and
// passes hit and move data to its right-hand neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_cell
   import chm_pkg::*;
#(
   parameter int IDX         = 0,
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire cell_ctl_type                    ctl,
   input  wire logic [KEY_WIDTH-1:0]            key_in,
   input  wire logic [VALUE_WIDTH-1:0]          value_in,
   input  wire logic [$clog2(CAPACITY+1)-1:0]   count_in,
   input  wire logic [KEY_WIDTH-1:0]            mv_key,
   input  wire logic [VALUE_WIDTH-1:0]          mv_value,
   input  wire logic                            hit_i,
   input  wire logic [VALUE_WIDTH-1:0]          hval_i,
   input  wire logic [KEY_WIDTH-1:0]            lkey_i,
   input  wire logic [VALUE_WIDTH-1:0]          lval_i,
   output logic                                 hit_o,
   output logic [VALUE_WIDTH-1:0]               hval_o,
   output logic [KEY_WIDTH-1:0]                 lkey_o,
   output logic [VALUE_WIDTH-1:0]               lval_o
);

   localparam int CW = $clog2(CAPACITY+1);
   localparam logic [CW-1:0] IDX_C  = CW'(IDX);
   localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);

   logic [KEY_WIDTH-1:0]   key_ff, key_in_nx;
   logic [VALUE_WIDTH-1:0] val_ff, val_in_nx;
   logic                   match_ff, match_in;
   logic                   hit_ff;
   logic [VALUE_WIDTH-1:0] hval_ff, lval_ff;
   logic [KEY_WIDTH-1:0]   lkey_ff;
   logic                   is_last;

   assign is_last = (count_in == NEXT_C);

   always_comb begin
      match_in  = match_ff;
      key_in_nx = key_ff;
      val_in_nx = val_ff;
      if (ctl.scan_start) begin
         match_in = (IDX_C < count_in) && (key_ff == key_in);
      end
      if (ctl.wr_value && match_ff) begin
         val_in_nx = value_in;
      end
      if (ctl.wr_new && (count_in == IDX_C)) begin
         key_in_nx = key_in;
         val_in_nx = value_in;
      end
      if (ctl.wr_move && match_ff) begin
         key_in_nx = mv_key;
         val_in_nx = mv_value;
      end
   end

   // Advance the carry one cell per cycle
   always_ff @(posedge clock) begin
      key_ff   <= key_in_nx;
      val_ff   <= val_in_nx;
      match_ff <= match_in;
      hit_ff   <= hit_i | match_ff;
      hval_ff  <= match_ff ? val_ff : hval_i;
      lkey_ff  <= is_last ? key_ff : lkey_i;
      lval_ff  <= is_last ? val_ff : lval_i;
   end

   assign hit_o  = hit_ff;
   assign hval_o = hval_ff;
   assign lkey_o = lkey_ff;
   assign lval_o = lval_ff;

endmodule

`default_nettype wire

// File: sv/chained_hash_map_dense_store.sv
// ----------------------------------------------------------------------------
// chained_hash_map_dense_store
// Key-value table with dense slots; insert, lookup and erase by key.
// ----------------------------------------------------------------------------
// A request is taken only when the sequencer is idle, so requests do not overlap;
//   the hit carry ripples through the row of slot cells one cell per cycle.
// Reset: synchronous; empties the table (count zero), clears the sequencer
//   and the response valid. Slot contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_dense_store
   import chm_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int CW  = $clog2(CAPACITY+1);
   localparam int SW  = $clog2(CAPACITY+3);
   localparam logic [SW-1:0] SCAN_LAST = SW'(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

   state_type state_ff, state_in;
   logic [SW-1:0] scnt_ff, scnt_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, commit_go;
   cell_ctl_type  ctl;

   // Carry chain between cells; index 0 is the empty input of the first cell
   logic                   hit_c  [CAPACITY+1];
   logic [VALUE_WIDTH-1:0] hval_c [CAPACITY+1];
   logic [KEY_WIDTH-1:0]   lkey_c [CAPACITY+1];
   logic [VALUE_WIDTH-1:0] lval_c [CAPACITY+1];

   logic                   end_hit;
   logic                   full;

   assign hit_c[0]  = 1'b0;
   assign hval_c[0] = '0;
   assign lkey_c[0] = '0;
   assign lval_c[0] = '0;

   assign end_hit = hit_c[CAPACITY];
   assign full    = (count_ff >= CAP_C);

   // Take a new request whenever the sequencer is free
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // Commit only when the response register can take the result
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scnt_ff == SCAN_LAST) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: cell control, count and response
   always_comb begin
      ctl          = '0;
      scnt_in      = scnt_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            scnt_in = '0;
         end
         ST_SCAN: begin
            ctl.scan_start = (scnt_ff == '0);
            scnt_in        = scnt_ff + SW'(1);
         end
         ST_COMMIT: begin
            if (commit_go) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               case (op_ff)
                  OP_INSERT: begin
                     rsp_in.found = end_hit;
                     if (end_hit) begin
                        ctl.wr_value = 1'b1;
                     end else if (full) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        ctl.wr_new = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  OP_LOOKUP: begin
                     rsp_in.found = end_hit;
                     if (end_hit) rsp_in.result_value = 32'(hval_c[CAPACITY]);
                  end
                  OP_ERASE: begin
                     rsp_in.found = end_hit;
                     if (end_hit) begin
                        ctl.wr_move = 1'b1;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  default: ;
               endcase
               rsp_in.entry_count = 6'(count_in);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scnt_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scnt_ff      <= scnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request payload for the whole scan
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff  <= req_data.op;
         key_ff <= KEY_WIDTH'(req_data.key);
         val_ff <= VALUE_WIDTH'(req_data.value);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Row of slot cells; slot i lives in cell i
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      chm_cell #(
         .IDX         (gi),
         .CAPACITY    (CAPACITY),
         .KEY_WIDTH   (KEY_WIDTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .key_in   (key_ff),
         .value_in (val_ff),
         .count_in (count_ff),
         .mv_key   (lkey_c[CAPACITY]),
         .mv_value (lval_c[CAPACITY]),
         .hit_i    (hit_c[gi]),
         .hval_i   (hval_c[gi]),
         .lkey_i   (lkey_c[gi]),
         .lval_i   (lval_c[gi]),
         .hit_o    (hit_c[gi+1]),
         .hval_o   (hval_c[gi+1]),
         .lkey_o   (lkey_c[gi+1]),
         .lval_o   (lval_c[gi+1])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (scnt_ff == '0))
      else $error("accepted request did not start a scan");

   a_full_nofound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.status && rsp_ff.found))
      else $error("full status on a hit");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COMMIT) |=> $stable(count_ff))
      else $error("entry count changed outside commit");

endmodule

`default_nettype wire

// File: tb/sv/chained_hash_map_dense_store_checker.sv
// ----------------------------------------------------------------------------
// chained_hash_map_dense_store_checker
// Watches request and response transfers, keeps a shadow key-value table with
// the same chaining and dense-slot behavior, and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_dense_store_checker
   import chm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           error_count,
   output int           pending_count,
   output int           hit_count,
   output int           full_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 32;
   localparam int NBUCKETS = 64;

   logic [5:0]  head [NBUCKETS];
   logic        head_ok [NBUCKETS];
   logic [5:0]  link [SLOTS];
   logic        link_ok [SLOTS];
   logic [31:0] slot_key [SLOTS];
   logic [31:0] slot_value [SLOTS];
   int          fill;
   rsp_type     expected_rsps [$];

   function automatic int bucket_of(logic [31:0] k);
      return int'(k[5:0]);
   endfunction

   // Walk the chain of a bucket; report the hit slot and its predecessor.
   function automatic bit find_slot(logic [31:0] k, output int slot, output int prev,
                                    output bit has_prev);
      int  cur;
      bit  cur_ok;
      int  b;
      b = bucket_of(k);
      cur = head[b];
      cur_ok = head_ok[b];
      prev = 0;
      has_prev = 0;
      slot = 0;
      for (int n = 0; n < SLOTS && cur_ok && cur < fill; n++) begin
         if (slot_key[cur] == k) begin
            slot = cur;
            return 1;
         end
         prev = cur;
         has_prev = 1;
         cur_ok = link_ok[cur];
         cur = link[cur];
      end
      return 0;
   endfunction

   // Unlink the hit, then move the last entry into the hole.
   function automatic void remove_slot(int idx, int prev, bit has_prev, int b);
      int last;
      int lb;
      int cur;
      bit cur_ok;
      last = fill - 1;
      if (has_prev) begin
         link[prev] = link[idx];
         link_ok[prev] = link_ok[idx];
      end else begin
         head[b] = link[idx];
         head_ok[b] = link_ok[idx];
      end
      if (idx == last) begin
         fill = last;
         return;
      end
      lb = bucket_of(slot_key[last]);
      if (head_ok[lb] && head[lb] == last) begin
         head[lb] = link[last];
         head_ok[lb] = link_ok[last];
      end else begin
         cur = head[lb];
         cur_ok = head_ok[lb];
         for (int n = 0; n < SLOTS && cur_ok && cur < fill; n++) begin
            if (link_ok[cur] && link[cur] == last) begin
               link[cur] = link[last];
               link_ok[cur] = link_ok[last];
               break;
            end
            cur_ok = link_ok[cur];
            cur = link[cur];
         end
      end
      slot_key[idx] = slot_key[last];
      slot_value[idx] = slot_value[last];
      link[idx] = head[lb];
      link_ok[idx] = head_ok[lb];
      head[lb] = idx[5:0];
      head_ok[lb] = 1;
      fill = last;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int      slot;
      int      prev;
      bit      has_prev;
      int      b;
      o = '0;
      b = bucket_of(r.key);
      case (op_type'(r.op))
         OP_INSERT: begin
            if (find_slot(r.key, slot, prev, has_prev)) begin
               slot_value[slot] = r.value;
               o.found = 1;
            end else if (fill >= SLOTS) begin
               o.status = 1;
            end else begin
               link[fill] = head[b];
               link_ok[fill] = head_ok[b];
               head[b] = fill[5:0];
               head_ok[b] = 1;
               slot_key[fill] = r.key;
               slot_value[fill] = r.value;
               fill++;
            end
         end
         OP_LOOKUP: begin
            if (find_slot(r.key, slot, prev, has_prev)) begin
               o.found = 1;
               o.result_value = slot_value[slot];
            end
         end
         OP_ERASE: begin
            if (fill > 0 && find_slot(r.key, slot, prev, has_prev)) begin
               o.found = 1;
               remove_slot(slot, prev, has_prev, b);
            end
         end
         default: ;
      endcase
      o.entry_count = fill[5:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      if (reset) begin
         for (int i = 0; i < NBUCKETS; i++) begin
            head[i] = '0;
            head_ok[i] = 0;
         end
         for (int i = 0; i < SLOTS; i++) begin
            link[i] = '0;
            link_ok[i] = 0;
            slot_key[i] = '0;
            slot_value[i] = '0;
         end
         fill = 0;
         expected_rsps.delete();
         error_count <= 0;
         pending_count <= 0;
         hit_count <= 0;
         full_count <= 0;
      end else begin
         errs = 0;
         // Retire the response first; a request in the same edge cannot affect it.
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               errs++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  errs++;
               end
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0h, got %0h",
                         want.result_value, rsp_data.result_value);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_data.entry_count);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(req_data);
            if (want.found) hit_count <= hit_count + 1;
            if (want.status) full_count <= full_count + 1;
            expected_rsps.push_back(want);
         end
         error_count <= error_count + errs;
         pending_count <= expected_rsps.size();
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/chained_hash_map_dense_store_test.sv
// ----------------------------------------------------------------------------
// chained_hash_map_dense_store_test
// Drives insert, lookup and erase traffic with random gaps and stalls, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_dense_store_test
   import chm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Margin after the last pending response before the verdict.
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 1568;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int hit_count;
   int full_count;
   int sent_count = 0;
   bit long_stall = 0;

   // Small pool of keys so that hits, collisions and a full table all happen.
   logic [31:0] key_pool [48];

   always #5 clock = ~clock;

   chained_hash_map_dense_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   chained_hash_map_dense_store_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .hit_count     (hit_count),
      .full_count    (full_count)
   );

   // Offer one request; hold it until the transfer, then drop valid unless
   // the next request follows with no gap.
   task automatic send_request(op_type op, logic [31:0] k, logic [31:0] v);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{op: op, key: k, value: v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 19) == 0) return $urandom();
      return key_pool[$urandom_range(0, 47)];
   endfunction

   // Receiver: random stall per response, plus one long hold-off.
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_stall) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            long_stall = 0;
         end
         hold = $urandom_range(0, 3);
         if ((sent_count / 200) % 3 == 1) hold = 0;
         if (hold > 0) begin
            rsp_ready <= 0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      int r;
      int waited;
      op_type op;
      for (int i = 0; i < 48; i++) begin
         // Share low bits among many keys to build long chains.
         key_pool[i] = {26'($urandom()), 6'(i % 6)};
         if (i < 16) key_pool[i][5:0] = 6'(i % 3);
      end
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty-table misses, field extremes, unused op, overwrite.
      send_request(OP_LOOKUP, 32'h0, 32'h0);
      send_request(OP_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_INSERT, 32'h0000_0040, 32'h1234_5678);
      send_request(OP_INSERT, 32'h0, 32'hA5A5_A5A5);
      send_request(OP_LOOKUP, 32'h0, 32'h0);
      send_request(OP_LOOKUP, 32'h0000_0040, 32'h0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_LOOKUP, 32'h0000_0080, 32'h0);
      send_request(OP_ERASE, 32'h0, 32'h0);
      send_request(OP_LOOKUP, 32'h0000_0040, 32'h0);
      send_request(OP_ERASE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_ERASE, 32'h0000_0040, 32'h0);
      // Fill to capacity, refuse one more, overwrite while full, then empty.
      for (int i = 0; i < 33; i++) send_request(OP_INSERT, 32'(i * 64 + 7), 32'(i));
      send_request(OP_INSERT, 32'h0000_0007, 32'hFFFF_FFFF);
      for (int i = 0; i < 33; i++) send_request(OP_ERASE, 32'(i * 64 + 7), 32'h0);

      // Random: phases lean toward inserts or erases so the table swings
      // between empty and full; a long receiver stall lands mid-run.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) long_stall = 1;
         r = $urandom_range(0, 99);
         if ((n / 150) % 2 == 0) op = (r < 55) ? OP_INSERT : (r < 80) ? OP_LOOKUP
                                     : (r < 97) ? OP_ERASE : OP_NONE;
         else op = (r < 20) ? OP_INSERT : (r < 50) ? OP_LOOKUP
                   : (r < 97) ? OP_ERASE : OP_NONE;
         send_request(op, pick_key(), $urandom());
      end
      req_valid <= 0;

      waited = 0;
      while (pending_count != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests: %0d key hits, %0d inserts refused on a full table.",
               sent_count, hit_count, full_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: fails the run if about 1650 items plus stalls have not finished.
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
